@@ hw/rtl/rbc_pkg.sv @@
// Shared types and constants for the rotor byte cipher.
package rbc_pkg;
  localparam int unsigned RotorSize = 256;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned KeyBytes  = 13;
  localparam logic [31:0] SeedInit  = 32'd123;
  localparam logic [16:0] SeedMod   = 17'd65521;
  localparam logic [4:0]  SeedFold  = 5'd15;   // 2^16 mod SeedMod
  localparam logic [0:0]  OP_CIPHER = 1'b0;
  localparam logic [0:0]  OP_REKEY  = 1'b1;
  localparam logic [0:0]  CFG_KEY_LOW  = 1'b0;
  localparam logic [0:0]  CFG_KEY_HIGH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,      // zero reflector, identity rotor, one entry a cycle
    ST_SEED,     // 13 seed steps
    ST_SMUL,     // seed = 5*seed + key
    ST_MOD,      // reduce modulo 65521 by folding the upper half
    ST_JMOD,     // j = (r & 255) mod (k+1)
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_RCHK,
    ST_PMOD,     // j = ((r>>8)&255) mod k
    ST_PRD,
    ST_PCHK,
    ST_NEXT,
    ST_INV_RD,
    ST_INV_WR,
    ST_C_ROT,
    ST_C_REF,
    ST_C_INV,
    ST_C_OUT,
    ST_RESP
  } rbc_state_t;

  typedef struct packed {
    rbc_state_t st;
    logic       start_rekey;
    logic       start_cipher;
  } rbc_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic div_done;
    logic idx_last;
    logic seed_last;
    logic k_zero;
    logic refl_nz;
    logic probe_last;
  } rbc_stat_t;
endpackage

@@ hw/rtl/rbc_stream_if.sv @@
// Valid/ready channel interfaces for the cipher.
interface rbc_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_in;
  modport source (output valid, output op, output data_in, input ready);
  modport sink (input valid, input op, input data_in, output ready);
endinterface

interface rbc_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       rekey_done;
  modport source (output valid, output data_out, output rekey_done, input ready);
  modport sink (input valid, input data_out, input rekey_done, output ready);
endinterface

@@ hw/rtl/rotor_byte_cipher_core.sv @@
// Top level of the single-rotor byte cipher.
//
//  channel  | direction | payload
//  in_      | sink      | op, data_in
//  out_     | source    | data_out, rekey_done
//  cfg_     | write     | cfg_index 0 key_low, 1 key_high
//
// A cipher word runs three dependent reads of the rotor, reflector and
// inverse memories, then the subtraction. The result is registered and valid
// in RESP, and the core is idle again in the cycle after the output handshake,
// so it takes no new word until the last result has been taken.
// A rekey word runs an init sweep over all 256 rotor entries, 13 seed steps,
// then per rotor entry a modulo 65521 by two folds, a divide and a swap, plus
// a second divide and reflector probes when the entry is still unpaired, and
// an inverse build.
// Reset is synchronous; it clears control, keys and positions. One word is in
// flight at a time; the result holds until out_ready.
module rotor_byte_cipher_core (
  input  logic          clk,
  input  logic          rst_n,
  rbc_in_if.sink        in_ch,
  rbc_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [63:0]   cfg_wdata
);
  rbc_pkg::rbc_cmd_t  cmd;
  rbc_pkg::rbc_stat_t stat;
  logic busy;
  logic in_fire, out_fire;

  // Accept a word only when idle.
  assign in_ch.ready  = !busy;
  assign in_fire      = in_ch.valid && !busy;
  assign out_ch.valid = (cmd.st == rbc_pkg::ST_RESP);
  assign out_fire     = out_ch.valid && out_ch.ready;

  rbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_op    (in_ch.op),
    .out_fire (out_fire),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  rbc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_ch.data_in),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .res_data  (out_ch.data_out),
    .res_rekey (out_ch.rekey_done)
  );
endmodule

@@ hw/rtl/rbc_ctrl.sv @@
// Sequencer for key expansion and byte ciphering.
module rbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_op,
  input  logic                out_fire,
  input  rbc_pkg::rbc_stat_t  stat,
  output rbc_pkg::rbc_cmd_t   cmd,
  output logic                busy
);
  rbc_pkg::rbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd.st           = state_r;
    cmd.start_rekey  = 1'b0;
    cmd.start_cipher = 1'b0;
    busy             = (state_r != rbc_pkg::ST_IDLE);
    unique case (state_r)
      rbc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_op == rbc_pkg::OP_REKEY) begin
            cmd.start_rekey = 1'b1;
            state_nxt = rbc_pkg::ST_CLR;
          end else begin
            cmd.start_cipher = 1'b1;
            state_nxt = rbc_pkg::ST_C_ROT;
          end
        end
      end
      rbc_pkg::ST_CLR:     if (stat.idx_last) state_nxt = rbc_pkg::ST_SEED;
      rbc_pkg::ST_SEED:    if (stat.seed_last) state_nxt = rbc_pkg::ST_SMUL;
      rbc_pkg::ST_SMUL:    state_nxt = rbc_pkg::ST_MOD;
      rbc_pkg::ST_MOD:     if (stat.mod_done) state_nxt = rbc_pkg::ST_JMOD;
      rbc_pkg::ST_JMOD:    if (stat.div_done) state_nxt = rbc_pkg::ST_SWAP_RD;
      rbc_pkg::ST_SWAP_RD: state_nxt = rbc_pkg::ST_SWAP_WR;
      rbc_pkg::ST_SWAP_WR: state_nxt = rbc_pkg::ST_RCHK;
      rbc_pkg::ST_RCHK: begin
        if (stat.refl_nz || stat.k_zero) state_nxt = rbc_pkg::ST_NEXT;
        else state_nxt = rbc_pkg::ST_PMOD;
      end
      rbc_pkg::ST_PMOD:    if (stat.div_done) state_nxt = rbc_pkg::ST_PRD;
      rbc_pkg::ST_PRD:     state_nxt = rbc_pkg::ST_PCHK;
      rbc_pkg::ST_PCHK: begin
        if (!stat.refl_nz || stat.probe_last) state_nxt = rbc_pkg::ST_NEXT;
        else state_nxt = rbc_pkg::ST_PRD;
      end
      rbc_pkg::ST_NEXT: begin
        if (stat.k_zero) state_nxt = rbc_pkg::ST_INV_RD;
        else state_nxt = rbc_pkg::ST_SMUL;
      end
      rbc_pkg::ST_INV_RD:  state_nxt = rbc_pkg::ST_INV_WR;
      rbc_pkg::ST_INV_WR: begin
        if (stat.idx_last) state_nxt = rbc_pkg::ST_RESP;
        else state_nxt = rbc_pkg::ST_INV_RD;
      end
      rbc_pkg::ST_C_ROT:   state_nxt = rbc_pkg::ST_C_REF;
      rbc_pkg::ST_C_REF:   state_nxt = rbc_pkg::ST_C_INV;
      rbc_pkg::ST_C_INV:   state_nxt = rbc_pkg::ST_C_OUT;
      rbc_pkg::ST_C_OUT:   state_nxt = rbc_pkg::ST_RESP;
      rbc_pkg::ST_RESP:    if (out_fire) state_nxt = rbc_pkg::ST_IDLE;
      default:             state_nxt = rbc_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ hw/rtl/rbc_dp.sv @@
// Tables, seed arithmetic and cipher datapath.
module rbc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rbc_pkg::rbc_cmd_t  cmd,
  input  logic [7:0]         in_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_idx,
  input  logic [63:0]        cfg_wdata,
  output rbc_pkg::rbc_stat_t stat,
  output logic [7:0]         res_data,
  output logic               res_rekey
);
  logic [7:0]  rot_mem [rbc_pkg::RotorSize];
  logic [7:0]  inv_mem [rbc_pkg::RotorSize];
  logic [7:0]  ref_mem [rbc_pkg::RotorSize];

  logic [63:0] key_low_r;
  logic [39:0] key_high_r;
  logic        keyed_r;
  logic [7:0]  p1_r, p2_r;
  logic [7:0]  din_r;       // cipher byte, held from acceptance
  logic [31:0] seed_r;
  logic [3:0]  kb_r;        // key byte index, i mod 13
  logic [7:0]  idx_r;       // clear / inverse sweep index
  logic [7:0]  k_r;
  logic [19:0] fold_r;      // first fold of the magnitude
  logic [31:0] mag_r;
  logic        mcnt_r;
  logic        neg_r;
  logic [15:0] r_r;
  logic [8:0]  drem_r;
  logic [7:0]  dq_r;
  logic [3:0]  dcnt_r;
  logic [7:0]  j_r;
  logic [7:0]  a_r, b_r;    // rotor read values, also cipher pipe
  logic [8:0]  probes_r;
  logic [7:0]  out_r;
  logic        rk_r;

  logic [7:0]  kbyte;
  logic [31:0] kext;
  logic [31:0] seed5;
  logic [19:0] fold1;
  logic [16:0] fold2;
  logic [16:0] rem_fin;
  logic [8:0]  divisor;
  logic [9:0]  drem_sh;

  always_comb begin
    logic [103:0] key;
    key   = {key_high_r, key_low_r};
    kbyte = key[kb_r*8 +: 8];
  end
  assign kext    = {{24{kbyte[7]}}, kbyte};
  assign seed5   = (seed_r << 2) + seed_r + kext;
  // 2^16 is congruent to 15 modulo 65521: fold the upper half down twice,
  // then one compare and subtract.
  assign fold1   = {4'd0, mag_r[31:16]} * {15'd0, rbc_pkg::SeedFold} + {4'd0, mag_r[15:0]};
  assign fold2   = {13'd0, fold_r[19:16]} * {12'd0, rbc_pkg::SeedFold} + {1'b0, fold_r[15:0]};
  assign rem_fin = (fold2 >= rbc_pkg::SeedMod) ? fold2 - rbc_pkg::SeedMod : fold2;
  assign divisor = (cmd.st == rbc_pkg::ST_JMOD) ? {1'b0, k_r} + 9'd1 : {1'b0, k_r};
  assign drem_sh = {drem_r, dq_r[7]};

  assign stat.mod_done   = mcnt_r;
  assign stat.div_done   = (dcnt_r == 4'd8);
  assign stat.idx_last   = (idx_r == 8'd255);
  assign stat.seed_last  = (kb_r == 4'(rbc_pkg::KeyBytes - 1));
  assign stat.k_zero     = (k_r == 8'd0);
  assign stat.refl_nz    = (b_r != 8'd0);
  assign stat.probe_last = (probes_r == {1'b0, k_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == rbc_pkg::CFG_KEY_LOW) key_low_r <= cfg_wdata;
      else key_high_r <= cfg_wdata[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyed_r <= 1'b0;
      p1_r    <= '0;
      p2_r    <= '0;
    end else if (cmd.start_rekey) begin
      keyed_r <= 1'b1;
      p1_r    <= '0;
      p2_r    <= '0;
    end else if (cmd.st == rbc_pkg::ST_C_OUT) begin
      p1_r <= p1_r + 8'd1;
      if (p1_r == 8'hFF) p2_r <= p2_r + 8'd1;
    end
  end

  // Tables: rotor, reflector and inverse memories; the rotor swap and the reflector pairing use a second port.
  always_ff @(posedge clk) begin
    case (cmd.st)
      rbc_pkg::ST_CLR: begin
        rot_mem[idx_r] <= idx_r;
        ref_mem[idx_r] <= 8'd0;
      end
      rbc_pkg::ST_SWAP_RD: begin
        a_r <= rot_mem[k_r];
      end
      rbc_pkg::ST_SWAP_WR: begin
        rot_mem[k_r] <= b_r;
        b_r <= ref_mem[k_r];
      end
      rbc_pkg::ST_PRD: b_r <= ref_mem[j_r];
      rbc_pkg::ST_INV_RD: a_r <= rot_mem[idx_r];
      rbc_pkg::ST_INV_WR: inv_mem[a_r] <= idx_r;
      rbc_pkg::ST_C_ROT: a_r <= rot_mem[din_r + p1_r];
      rbc_pkg::ST_C_REF: b_r <= ref_mem[a_r + p2_r];
      rbc_pkg::ST_C_INV: a_r <= inv_mem[b_r - p2_r];
      default: ;
    endcase
    // second port of rotor: read j during SWAP_RD, write j during SWAP_WR
    if (cmd.st == rbc_pkg::ST_SWAP_RD) b_r <= rot_mem[j_r];
    if (cmd.st == rbc_pkg::ST_SWAP_WR) rot_mem[j_r] <= a_r;
    if (cmd.st == rbc_pkg::ST_PCHK && b_r == 8'd0) begin
      ref_mem[k_r] <= j_r;
      ref_mem[j_r] <= k_r;
    end
  end

  // Seed, modulo and small divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= 1'b0;
    end else begin
      if (cmd.start_rekey) begin
        idx_r  <= '0;
        seed_r <= rbc_pkg::SeedInit;
        kb_r   <= '0;
        k_r    <= 8'd255;
        rk_r   <= 1'b1;
      end
      if (cmd.start_cipher) begin
        rk_r  <= 1'b0;
        din_r <= in_data;
      end
      case (cmd.st)
        rbc_pkg::ST_CLR: begin
          idx_r <= idx_r + 8'd1;
          if (stat.idx_last) kb_r <= '0;
        end
        rbc_pkg::ST_SEED: begin
          seed_r <= seed_r * kext + 32'(kb_r);
          kb_r   <= stat.seed_last ? 4'd0 : kb_r + 4'd1;
        end
        rbc_pkg::ST_SMUL: begin
          seed_r <= seed5;
          kb_r   <= stat.seed_last ? 4'd0 : kb_r + 4'd1;
          mcnt_r <= 1'b0;
          neg_r  <= seed5[31];
          mag_r  <= seed5[31] ? 32'd0 - seed5 : seed5;
        end
        rbc_pkg::ST_MOD: begin
          if (!stat.mod_done) begin
            fold_r <= fold1;
            mcnt_r <= 1'b1;
          end else begin
            r_r    <= neg_r ? 16'(17'd0 - rem_fin) : rem_fin[15:0];
            dq_r   <= neg_r ? 8'(17'd0 - rem_fin) : rem_fin[7:0];
            drem_r <= '0;
            dcnt_r <= '0;
          end
        end
        rbc_pkg::ST_JMOD, rbc_pkg::ST_PMOD: begin
          if (!stat.div_done) begin
            dq_r   <= dq_r << 1;
            drem_r <= (drem_sh >= {1'b0, divisor}) ?
                      9'(drem_sh - {1'b0, divisor}) : drem_sh[8:0];
            dcnt_r <= dcnt_r + 4'd1;
          end else begin
            j_r <= drem_r[7:0];
          end
        end
        rbc_pkg::ST_RCHK: begin
          dq_r     <= r_r[15:8];
          drem_r   <= '0;
          dcnt_r   <= '0;
          probes_r <= '0;
        end
        rbc_pkg::ST_PCHK: begin
          if (b_r != 8'd0) begin
            j_r      <= ((j_r + 8'd1) == k_r) ? 8'd0 : j_r + 8'd1;
            probes_r <= probes_r + 9'd1;
          end
        end
        rbc_pkg::ST_NEXT: begin
          k_r   <= k_r - 8'd1;
          idx_r <= '0;
        end
        rbc_pkg::ST_INV_WR: idx_r <= idx_r + 8'd1;
        rbc_pkg::ST_C_OUT: out_r <= keyed_r ? a_r - p1_r : 8'd0 - p1_r;
        default: ;
      endcase
      if (cmd.start_rekey) out_r <= 8'd0;
    end
  end

  assign res_data  = rk_r ? 8'd0 : out_r;
  assign res_rekey = rk_r;
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the rotor byte cipher core.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ClkHalf    = 4;
  localparam int unsigned IdleLimit  = 400000;  // covers worst-case rekey probing
  localparam int unsigned SegWords   = 270;     // long enough to carry into pos 2

  typedef struct {
    logic [7:0] data_out;
    logic       rekey_done;
  } cipher_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = rbc_pkg::CFG_KEY_LOW;
  logic [63:0] cfg_wdata = '0;

  rbc_in_if  in_ch  (.clk(clk));
  rbc_out_if out_ch (.clk(clk));

  rotor_byte_cipher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(ClkHalf) clk = ~clk;

  // Shadow copy of the cipher state, kept in step with accepted words.
  logic [63:0] key_lo_q;
  logic [39:0] key_hi_q;
  logic [7:0]  rot_q [rbc_pkg::RotorSize];
  logic [7:0]  inv_q [rbc_pkg::RotorSize];
  logic [7:0]  refl_q [rbc_pkg::RotorSize];
  logic [7:0]  pos1_q, pos2_q;

  cipher_word_t pending_words[$];
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  bit           no_send_gaps = 1'b0;
  bit           no_recv_stalls = 1'b0;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.op      = rbc_pkg::OP_CIPHER;
    in_ch.data_in = '0;
    out_ch.ready  = 1'b0;
  end

  // Key byte idx, sign-extended to 32 bits.
  function automatic int key_byte(int idx);
    logic [7:0] b;
    begin
      b = (idx < 8) ? key_lo_q[8*idx +: 8] : key_hi_q[8*(idx-8) +: 8];
      return int'($signed(b));
    end
  endfunction

  // Rebuild rotor, reflector and inverse from the current key; clear positions.
  function automatic void expand_rotor();
    int seed, rem, k, j, n;
    logic [31:0] rbits;
    logic [7:0] t;
    begin
      for (int i = 0; i < rbc_pkg::RotorSize; i++) begin
        rot_q[i]  = 8'(i);
        refl_q[i] = '0;
        inv_q[i]  = '0;
      end
      pos1_q = '0;
      pos2_q = '0;
      seed = int'(rbc_pkg::SeedInit);
      for (int i = 0; i < rbc_pkg::KeyBytes; i++) seed = seed * key_byte(i) + i;
      for (int i = 0; i < rbc_pkg::RotorSize; i++) begin
        k = rbc_pkg::RotorSize - 1 - i;
        seed = 5 * seed + key_byte(i % rbc_pkg::KeyBytes);
        rem = seed % 65521;        // truncates toward zero, as in C
        rbits = rem;
        j = int'(rbits[7:0]) % (k + 1);
        t = rot_q[k]; rot_q[k] = rot_q[j]; rot_q[j] = t;
        if (refl_q[k] != 0 || k == 0) continue;
        j = int'(rbits[15:8]) % k;
        // probe upward for a free reflector slot, at most k tries
        for (n = 0; n < k && refl_q[j] != 0; n++) j = (j + 1) % k;
        if (refl_q[j] != 0) continue;
        refl_q[k] = 8'(j);
        refl_q[j] = 8'(k);
      end
      for (int i = 0; i < rbc_pkg::RotorSize; i++) inv_q[rot_q[i]] = 8'(i);
    end
  endfunction

  // Expected result of one word; advances the shadow state.
  function automatic cipher_word_t predict_word(logic op, logic [7:0] d);
    cipher_word_t w;
    logic [7:0] a, b, c;
    begin
      if (op == rbc_pkg::OP_REKEY) begin
        expand_rotor();
        w.data_out = '0;
        w.rekey_done = 1'b1;
      end else begin
        a = rot_q[8'(d + pos1_q)];
        b = refl_q[8'(a + pos2_q)];
        c = inv_q[8'(b - pos2_q)];
        w.data_out = 8'(c - pos1_q);
        w.rekey_done = 1'b0;
        pos1_q = pos1_q + 8'd1;
        if (pos1_q == 0) pos2_q = pos2_q + 8'd1;
      end
      return w;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned x;
    begin
      x = $urandom_range(0, 99);
      if (x < 60) return 0;
      if (x < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
    end
  endfunction

  // Send one word; valid stays high across back-to-back words.
  task automatic send_word(input logic op, input logic [7:0] d);
    int unsigned gap;
    begin
      gap = no_send_gaps ? 0 : pick_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.op      <= op;
      in_ch.data_in <= d;
      do @(posedge clk); while (!in_ch.ready);
      pending_words.push_back(predict_word(op, d));
    end
  endtask

  // Hold until every expected word is back, then let the core settle.
  task automatic drain();
    begin
      @(posedge clk);
      in_ch.valid <= 1'b0;
      wait (pending_words.size() == 0);
      repeat (8) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [63:0] value);
    begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= value;
      @(posedge clk);
      cfg_we <= 1'b0;
      if (idx == rbc_pkg::CFG_KEY_LOW) key_lo_q = value;
      else key_hi_q = value[39:0];
    end
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    begin
      drain();
      write_reg(rbc_pkg::CFG_KEY_LOW, lo);
      write_reg(rbc_pkg::CFG_KEY_HIGH, hi);
    end
  endtask

  // Before the first rekey the output is minus pos1 whatever the tables hold; positions still step.
  task automatic test_cold_cipher();
    begin
      send_word(rbc_pkg::OP_CIPHER, 8'h00);
      send_word(rbc_pkg::OP_CIPHER, 8'hff);
      send_word(rbc_pkg::OP_CIPHER, 8'h5a);
    end
  endtask

  // Extreme keys: zero, all ones, sign bits only; upper cfg bits must be dropped.
  task automatic test_key_extremes();
    begin
      load_key('0, '0);
      send_word(rbc_pkg::OP_REKEY, 8'hff);
      send_word(rbc_pkg::OP_CIPHER, 8'h00);
      send_word(rbc_pkg::OP_CIPHER, 8'hff);
      load_key('1, '1);
      send_word(rbc_pkg::OP_REKEY, 8'h00);
      send_word(rbc_pkg::OP_CIPHER, 8'h00);
      send_word(rbc_pkg::OP_CIPHER, 8'hff);
      send_word(rbc_pkg::OP_CIPHER, 8'h80);
      load_key({8{8'h80}}, {24'hffffff, {5{8'h80}}});
      send_word(rbc_pkg::OP_REKEY, 8'h00);
      send_word(rbc_pkg::OP_CIPHER, 8'h7f);
      send_word(rbc_pkg::OP_CIPHER, 8'h01);
      // rekey again with the same key: positions clear again
      send_word(rbc_pkg::OP_REKEY, 8'h00);
      send_word(rbc_pkg::OP_CIPHER, 8'h7f);
    end
  endtask

  // Random keys, each followed by a long run of random bytes so pos1 wraps.
  task automatic test_random_traffic();
    begin
      for (int s = 0; s < 5; s++) begin
        load_key({$urandom, $urandom}, {$urandom, $urandom});
        no_send_gaps   = (s == 2);
        no_recv_stalls = (s == 3);
        send_word(rbc_pkg::OP_REKEY, 8'($urandom));
        for (int i = 0; i < SegWords; i++) begin
          send_word(rbc_pkg::OP_CIPHER, 8'($urandom));
          // pause once until everything is back, then resume mid-stream
          if (s == 1 && i == 100) drain();
        end
      end
      no_send_gaps   = 1'b0;
      no_recv_stalls = 1'b0;
    end
  endtask

  // Receiver: random backpressure, same gap profile as the sender.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (no_recv_stalls) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  // Check each returned word against the oldest expectation.
  always @(posedge clk) begin
    cipher_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word data_out=%h rekey_done=%b",
                   out_ch.data_out, out_ch.rekey_done);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_ch.data_out !== exp_w.data_out || out_ch.rekey_done !== exp_w.rekey_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: data_out exp %h got %h, rekey_done exp %b got %b",
                     exp_w.data_out, out_ch.data_out, exp_w.rekey_done,
                     out_ch.rekey_done);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    key_lo_q = '0;
    key_hi_q = '0;
    for (int i = 0; i < rbc_pkg::RotorSize; i++) begin
      rot_q[i] = '0; inv_q[i] = '0; refl_q[i] = '0;
    end
    pos1_q = '0;
    pos2_q = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_cold_cipher();
    test_key_extremes();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_stream_if.sv
hw/rtl/rbc_ctrl.sv
hw/rtl/rbc_dp.sv
hw/rtl/rotor_byte_cipher_core.sv
dv/tb_top.sv
